// ===== hw/rtl/m68kea_pkg.sv =====
package m68kea_pkg;

	localparam logic [1:0] OP_WRITE_D = 2'd0;
	localparam logic [1:0] OP_WRITE_A = 2'd1;
	localparam logic [1:0] OP_START   = 2'd2;
	localparam logic [1:0] OP_REPLY   = 2'd3;

	localparam logic [1:0] KIND_DONE  = 2'd0;
	localparam logic [1:0] KIND_WORD  = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;
	localparam logic [1:0] KIND_INVAL = 2'd3;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_WAIT_D16 = 3'd1;
	localparam logic [2:0] PH_WAIT_EXT = 3'd2;
	localparam logic [2:0] PH_WAIT_BD  = 3'd3;
	localparam logic [2:0] PH_WAIT_OD  = 3'd4;
	localparam logic [2:0] PH_WAIT_IND = 3'd5;

	localparam logic [2:0] MODE_DN   = 3'd0;
	localparam logic [2:0] MODE_AN   = 3'd1;
	localparam logic [2:0] MODE_IND  = 3'd2;
	localparam logic [2:0] MODE_POST = 3'd3;
	localparam logic [2:0] MODE_PRE  = 3'd4;
	localparam logic [2:0] MODE_D16  = 3'd5;
	localparam logic [2:0] MODE_IDX  = 3'd6;

	localparam logic [1:0] BDS_WORD = 2'd2;
	localparam logic [1:0] BDS_LONG = 2'd3;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sext8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

// ===== hw/rtl/m68k_effective_address_unit.sv =====
// Effective address unit for 68000/68020 register addressing modes 0 to 6.
// Input channel (valid/ready): one word per item: a data or address register
// write, a start (mode, register, size, pc in data_value) or a bus reply.
// Output channel (out_valid/out_ready): kind, address and next_pc. Starts
// always produce a word; replies produce one while a calculation is pending;
// register writes produce none. Fetch requests (kind 1 or 2) ask the host to
// read memory at address and return the data as a reply item.
// The result word is registered: an item accepted at one edge shows its result
// word after that edge. One item is accepted every cycle unless output stalls.
// The result register is refilled in the same cycle that its word is taken,
// so ready is high whenever the output is empty or its word is being taken,
// and low only while an untaken result word waits.
// Reset clears the register file, the program counter and the pending state.
// When the receiver stalls, the result word is held and input stops.
module m68k_effective_address_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  operation,
	input  logic [2:0]  reg_index,
	input  logic [2:0]  mode,
	input  logic [1:0]  operand_size,
	input  logic [31:0] data_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] address,
	output logic [31:0] next_pc
);

	logic [31:0] dreg_q [8];
	logic [31:0] areg_q [8];
	logic [31:0] pc_q;
	logic [2:0]  phase_q;
	logic [2:0]  ea_q;
	logic [15:0] ext_q;
	logic [31:0] bd_q;
	logic [31:0] od_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] addr_q;
	logic [31:0] npc_q;

	logic        acc;
	logic        emit;
	logic [1:0]  e_kind;
	logic [31:0] e_addr;
	logic [31:0] pc_n;
	logic [2:0]  phase_n;
	logic [31:0] bd_n;
	logic [31:0] od_n;
	logic        awr;
	logic [31:0] awr_val;
	logic [31:0] step;
	logic [15:0] w;
	logic [31:0] idx_raw;
	logic [31:0] idx_sc;
	logic [31:0] fbase;
	logic [31:0] findex;
	logic [31:0] bd_use;
	logic [2:0]  iis;
	logic [1:0]  bds;

	assign ready = !out_valid_q || out_ready;
	assign acc = valid && ready;
	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign address = addr_q;
	assign next_pc = npc_q;

	always_comb begin
		logic [2:0] r;
		w = (operation == m68kea_pkg::OP_REPLY && phase_q == m68kea_pkg::PH_WAIT_EXT)
			? data_value[15:0] : ext_q;
		r = w[14:12];
		idx_raw = w[15] ? areg_q[r] : dreg_q[r];
		if (!w[11])
			idx_raw = m68kea_pkg::sext16(idx_raw[15:0]);
		idx_sc = idx_raw << w[10:9];
		fbase = w[7] ? 32'd0 : areg_q[ea_q];
		findex = w[6] ? 32'd0 : idx_sc;
		iis = w[2:0];
		bds = w[5:4];
	end

	always_comb begin
		case (operand_size)
			2'd0: step = (reg_index == 3'd7) ? 32'd2 : 32'd1;
			2'd1: step = 32'd2;
			2'd2: step = 32'd4;
			default: step = 32'd1;
		endcase
	end

	always_comb begin
		logic [31:0] pc_bd;
		logic        do_after;
		logic [31:0] inter;
		emit = 1'b0;
		e_kind = m68kea_pkg::KIND_DONE;
		e_addr = '0;
		pc_n = pc_q;
		phase_n = phase_q;
		bd_n = bd_q;
		od_n = od_q;
		awr = 1'b0;
		awr_val = '0;
		do_after = 1'b0;
		bd_use = bd_q;
		pc_bd = pc_q;
		inter = '0;
		case (operation)
			m68kea_pkg::OP_START: begin
				emit = 1'b1;
				pc_n = data_value;
				phase_n = m68kea_pkg::PH_IDLE;
				case (mode)
					m68kea_pkg::MODE_DN, m68kea_pkg::MODE_AN:
						e_addr = {29'd0, reg_index};
					m68kea_pkg::MODE_IND:
						e_addr = areg_q[reg_index];
					m68kea_pkg::MODE_POST: begin
						e_addr = areg_q[reg_index];
						awr = 1'b1;
						awr_val = areg_q[reg_index] + step;
					end
					m68kea_pkg::MODE_PRE: begin
						awr = 1'b1;
						awr_val = areg_q[reg_index] - step;
						e_addr = awr_val;
					end
					m68kea_pkg::MODE_D16: begin
						phase_n = m68kea_pkg::PH_WAIT_D16;
						e_kind = m68kea_pkg::KIND_WORD;
						e_addr = data_value;
					end
					m68kea_pkg::MODE_IDX: begin
						phase_n = m68kea_pkg::PH_WAIT_EXT;
						e_kind = m68kea_pkg::KIND_WORD;
						e_addr = data_value;
					end
					default: begin
						e_kind = m68kea_pkg::KIND_INVAL;
					end
				endcase
			end
			m68kea_pkg::OP_REPLY: begin
				case (phase_q)
					m68kea_pkg::PH_WAIT_D16: begin
						emit = 1'b1;
						pc_n = pc_q + 32'd2;
						phase_n = m68kea_pkg::PH_IDLE;
						e_addr = areg_q[ea_q] + m68kea_pkg::sext16(data_value[15:0]);
					end
					m68kea_pkg::PH_WAIT_EXT: begin
						emit = 1'b1;
						pc_n = pc_q + 32'd2;
						pc_bd = pc_q + 32'd2;
						phase_n = m68kea_pkg::PH_IDLE;
						if (!w[8]) begin
							e_addr = areg_q[ea_q] + m68kea_pkg::sext8(w[7:0]) + idx_sc;
						end else if (iis == 3'd4) begin
							e_kind = m68kea_pkg::KIND_INVAL;
						end else begin
							bd_n = '0;
							bd_use = '0;
							if (bds == m68kea_pkg::BDS_WORD) begin
								phase_n = m68kea_pkg::PH_WAIT_BD;
								e_kind = m68kea_pkg::KIND_WORD;
								e_addr = pc_bd;
							end else if (bds == m68kea_pkg::BDS_LONG) begin
								phase_n = m68kea_pkg::PH_WAIT_BD;
								e_kind = m68kea_pkg::KIND_LONG;
								e_addr = pc_bd;
							end else begin
								do_after = 1'b1;
							end
						end
					end
					m68kea_pkg::PH_WAIT_BD: begin
						emit = 1'b1;
						if (bds == m68kea_pkg::BDS_WORD) begin
							bd_use = m68kea_pkg::sext16(data_value[15:0]);
							pc_bd = pc_q + 32'd2;
						end else begin
							bd_use = data_value;
							pc_bd = pc_q + 32'd4;
						end
						bd_n = bd_use;
						pc_n = pc_bd;
						do_after = 1'b1;
					end
					m68kea_pkg::PH_WAIT_OD: begin
						emit = 1'b1;
						if (iis[1:0] == 2'd2) begin
							od_n = m68kea_pkg::sext16(data_value[15:0]);
							pc_n = pc_q + 32'd2;
						end else begin
							od_n = data_value;
							pc_n = pc_q + 32'd4;
						end
						phase_n = m68kea_pkg::PH_WAIT_IND;
						e_kind = m68kea_pkg::KIND_LONG;
						e_addr = fbase + bd_q + ((iis <= 3'd3) ? findex : 32'd0);
					end
					m68kea_pkg::PH_WAIT_IND: begin
						emit = 1'b1;
						phase_n = m68kea_pkg::PH_IDLE;
						e_addr = data_value + od_q + ((iis >= 3'd5) ? findex : 32'd0);
					end
					default: begin
						emit = 1'b0;
					end
				endcase
				if (do_after) begin
					inter = fbase + bd_use;
					if (iis == 3'd0) begin
						phase_n = m68kea_pkg::PH_IDLE;
						e_kind = m68kea_pkg::KIND_DONE;
						e_addr = inter + findex;
					end else begin
						od_n = '0;
						if (iis[1:0] == 2'd2 || iis[1:0] == 2'd3) begin
							phase_n = m68kea_pkg::PH_WAIT_OD;
							e_kind = (iis[1:0] == 2'd2) ? m68kea_pkg::KIND_WORD
								: m68kea_pkg::KIND_LONG;
							e_addr = pc_bd;
						end else begin
							phase_n = m68kea_pkg::PH_WAIT_IND;
							e_kind = m68kea_pkg::KIND_LONG;
							e_addr = inter + ((iis <= 3'd3) ? findex : 32'd0);
						end
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				dreg_q[i] <= '0;
				areg_q[i] <= '0;
			end
			pc_q <= '0;
			phase_q <= m68kea_pkg::PH_IDLE;
			ea_q <= '0;
			ext_q <= '0;
			bd_q <= '0;
			od_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			if (acc) begin
				if (operation == m68kea_pkg::OP_WRITE_D)
					dreg_q[reg_index] <= data_value;
				if (operation == m68kea_pkg::OP_WRITE_A)
					areg_q[reg_index] <= data_value;
				if (awr)
					areg_q[reg_index] <= awr_val;
				if (operation == m68kea_pkg::OP_START)
					ea_q <= reg_index;
				if (operation == m68kea_pkg::OP_REPLY &&
					phase_q == m68kea_pkg::PH_WAIT_EXT)
					ext_q <= data_value[15:0];
				pc_q <= pc_n;
				phase_q <= phase_n;
				bd_q <= bd_n;
				od_q <= od_n;
				if (emit)
					out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			kind_q <= e_kind;
			addr_q <= e_addr;
			npc_q <= pc_n;
		end
	end

endmodule

// ===== hw/rtl/m68kea_checker.sv =====
module m68kea_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [31:0] address
);

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && operation == m68kea_pkg::OP_START |=> out_valid)
		else $error("start word gave no result");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && (operation == m68kea_pkg::OP_WRITE_D ||
		operation == m68kea_pkg::OP_WRITE_A) |=> !out_valid)
		else $error("register write gave a result");

	a_inval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == m68kea_pkg::KIND_INVAL |-> address == 32'd0)
		else $error("invalid result with nonzero address");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> ready)
		else $error("not ready with empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(address) && $stable(kind))
		else $error("stalled result changed");

endmodule

bind m68k_effective_address_unit m68kea_checker u_checker (
	.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
	.operation(operation), .out_valid(out_valid), .out_ready(out_ready),
	.kind(kind), .address(address)
);

// ===== test/m68k_effective_address_unit_tb.sv =====
`timescale 1ns / 100ps

module m68k_effective_address_unit_tb;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  rg;
		logic [2:0]  md;
		logic [1:0]  sz;
		logic [31:0] val;
	} word_t;

	typedef struct packed {
		logic [1:0]  kd;
		logic [31:0] addr;
		logic [31:0] pc;
	} ea_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid = 1'b0;
	logic        ready;
	logic [1:0]  operation = m68kea_pkg::OP_WRITE_D;
	logic [2:0]  reg_index = '0;
	logic [2:0]  mode = m68kea_pkg::MODE_DN;
	logic [1:0]  operand_size = '0;
	logic [31:0] data_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] address;
	logic [31:0] next_pc;

	m68k_effective_address_unit u_top (.*);

	always #6 clk = ~clk;

	word_t      pending_words[$];
	ea_result_t expected_results[$];
	int         error_count = 0;
	bit         quiet_tail = 0;
	bit         hold_sender = 0;
	int         send_gap = 0;
	int         recv_gap = 0;

	logic [31:0] m_dreg[8];
	logic [31:0] m_areg[8];
	logic [31:0] m_pc;
	logic [2:0]  m_phase;
	logic [2:0]  m_ea_reg;
	logic [15:0] m_ext;
	logic [31:0] m_bd;
	logic [31:0] m_od;

	function automatic logic [31:0] ea_index(input logic [15:0] w);
		logic [31:0] v;
		v = w[15] ? m_areg[w[14:12]] : m_dreg[w[14:12]];
		if (!w[11])
			v = {{16{v[15]}}, v[15:0]};
		return v << w[10:9];
	endfunction

	function automatic logic [31:0] ea_full_index(input logic [15:0] w);
		return w[6] ? 32'd0 : ea_index(w);
	endfunction

	function automatic logic [31:0] ea_full_base(input logic [15:0] w);
		return w[7] ? 32'd0 : m_areg[m_ea_reg];
	endfunction

	function automatic ea_result_t ea_indirect_request();
		logic [31:0] t;
		t = ea_full_base(m_ext) + m_bd;
		if (m_ext[2:0] <= 3)
			t += ea_full_index(m_ext);
		m_phase = m68kea_pkg::PH_WAIT_IND;
		return '{m68kea_pkg::KIND_LONG, t, m_pc};
	endfunction

	function automatic ea_result_t ea_after_base_disp();
		if (m_ext[2:0] == 0) begin
			m_phase = m68kea_pkg::PH_IDLE;
			return '{m68kea_pkg::KIND_DONE,
				ea_full_base(m_ext) + m_bd + ea_full_index(m_ext), m_pc};
		end
		m_od = 0;
		if (m_ext[1:0] == 2'd2) begin
			m_phase = m68kea_pkg::PH_WAIT_OD;
			return '{m68kea_pkg::KIND_WORD, m_pc, m_pc};
		end
		if (m_ext[1:0] == 2'd3) begin
			m_phase = m68kea_pkg::PH_WAIT_OD;
			return '{m68kea_pkg::KIND_LONG, m_pc, m_pc};
		end
		return ea_indirect_request();
	endfunction

	function automatic logic [31:0] ea_step(input logic [2:0] r, input logic [1:0] s);
		case (s)
			2'd0: return r == 3'd7 ? 32'd2 : 32'd1;
			2'd1: return 32'd2;
			2'd2: return 32'd4;
			default: return 32'd1;
		endcase
	endfunction

	// Returns 1 and the expected word when the item yields one.
	function automatic bit ea_predict(input word_t it, output ea_result_t r);
		logic [31:0] a;
		r = '0;
		case (it.op)
			m68kea_pkg::OP_WRITE_D: begin
				m_dreg[it.rg] = it.val;
				return 0;
			end
			m68kea_pkg::OP_WRITE_A: begin
				m_areg[it.rg] = it.val;
				return 0;
			end
			m68kea_pkg::OP_START: begin
				m_pc = it.val;
				m_ea_reg = it.rg;
				m_phase = m68kea_pkg::PH_IDLE;
				case (it.md)
					m68kea_pkg::MODE_DN, m68kea_pkg::MODE_AN:
						r = '{m68kea_pkg::KIND_DONE, {29'd0, it.rg}, m_pc};
					m68kea_pkg::MODE_IND:
						r = '{m68kea_pkg::KIND_DONE, m_areg[it.rg], m_pc};
					m68kea_pkg::MODE_POST: begin
						a = m_areg[it.rg];
						m_areg[it.rg] = a + ea_step(it.rg, it.sz);
						r = '{m68kea_pkg::KIND_DONE, a, m_pc};
					end
					m68kea_pkg::MODE_PRE: begin
						m_areg[it.rg] -= ea_step(it.rg, it.sz);
						r = '{m68kea_pkg::KIND_DONE, m_areg[it.rg], m_pc};
					end
					m68kea_pkg::MODE_D16: begin
						m_phase = m68kea_pkg::PH_WAIT_D16;
						r = '{m68kea_pkg::KIND_WORD, m_pc, m_pc};
					end
					m68kea_pkg::MODE_IDX: begin
						m_phase = m68kea_pkg::PH_WAIT_EXT;
						r = '{m68kea_pkg::KIND_WORD, m_pc, m_pc};
					end
					default: r = '{m68kea_pkg::KIND_INVAL, 32'd0, m_pc};
				endcase
				return 1;
			end
			default: begin
				case (m_phase)
					m68kea_pkg::PH_WAIT_D16: begin
						m_pc += 2;
						m_phase = m68kea_pkg::PH_IDLE;
						r = '{m68kea_pkg::KIND_DONE,
							m_areg[m_ea_reg] + {{16{it.val[15]}}, it.val[15:0]}, m_pc};
					end
					m68kea_pkg::PH_WAIT_EXT: begin
						m_pc += 2;
						m_ext = it.val[15:0];
						if (!m_ext[8]) begin
							m_phase = m68kea_pkg::PH_IDLE;
							r = '{m68kea_pkg::KIND_DONE,
								m_areg[m_ea_reg] + {{24{m_ext[7]}}, m_ext[7:0]}
								+ ea_index(m_ext), m_pc};
						end else if (m_ext[2:0] == 3'd4) begin
							m_phase = m68kea_pkg::PH_IDLE;
							r = '{m68kea_pkg::KIND_INVAL, 32'd0, m_pc};
						end else begin
							m_bd = 0;
							if (m_ext[5:4] == m68kea_pkg::BDS_WORD) begin
								m_phase = m68kea_pkg::PH_WAIT_BD;
								r = '{m68kea_pkg::KIND_WORD, m_pc, m_pc};
							end else if (m_ext[5:4] == m68kea_pkg::BDS_LONG) begin
								m_phase = m68kea_pkg::PH_WAIT_BD;
								r = '{m68kea_pkg::KIND_LONG, m_pc, m_pc};
							end else
								r = ea_after_base_disp();
						end
					end
					m68kea_pkg::PH_WAIT_BD: begin
						if (m_ext[5:4] == m68kea_pkg::BDS_WORD) begin
							m_bd = {{16{it.val[15]}}, it.val[15:0]};
							m_pc += 2;
						end else begin
							m_bd = it.val;
							m_pc += 4;
						end
						r = ea_after_base_disp();
					end
					m68kea_pkg::PH_WAIT_OD: begin
						if (m_ext[1:0] == 2'd2) begin
							m_od = {{16{it.val[15]}}, it.val[15:0]};
							m_pc += 2;
						end else begin
							m_od = it.val;
							m_pc += 4;
						end
						r = ea_indirect_request();
					end
					m68kea_pkg::PH_WAIT_IND: begin
						a = it.val + m_od;
						if (m_ext[2:0] >= 3'd5)
							a += ea_full_index(m_ext);
						m_phase = m68kea_pkg::PH_IDLE;
						r = '{m68kea_pkg::KIND_DONE, a, m_pc};
					end
					default: return 0;
				endcase
				return 1;
			end
		endcase
	endfunction

	// Driver.
	always @(posedge clk) begin
		ea_result_t r;
		if (arst_n) begin
			if (valid && ready) begin
				if (ea_predict('{operation, reg_index, mode, operand_size, data_value}, r))
					expected_results.push_back(r);
				void'(pending_words.pop_front());
			end
			if (!(valid && !ready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					valid <= 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 14) == 0) begin
					send_gap <= $urandom_range(0, 10);
					valid <= 1'b0;
				end else if (pending_words.size() > (valid && ready ? 0 : 0) &&
						!hold_sender) begin
					valid <= 1'b1;
					{operation, reg_index, mode, operand_size, data_value} <= pending_words[0];
				end else
					valid <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		ea_result_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected word kind=%0d address=%h next_pc=%h",
						$time, kind, address, next_pc);
					error_count++;
				end else begin
					e = expected_results.pop_front();
					if (kind !== e.kd || address !== e.addr || next_pc !== e.pc) begin
						$display({"%0t: expected kind=%0d address=%h next_pc=%h, ",
							"actual kind=%0d address=%h next_pc=%h"},
							$time, e.kd, e.addr, e.pc, kind, address, next_pc);
						error_count++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 14) == 0) begin
				recv_gap <= $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_word(input logic [1:0] op, input logic [2:0] rg,
			input logic [2:0] md, input logic [1:0] sz, input logic [31:0] v);
		pending_words.push_back('{op, rg, md, sz, v});
	endtask

	// One indexed sequence with a well-formed reply for every request.
	task automatic queue_indexed(input logic [15:0] ext);
		logic [2:0] iis;
		queue_word(m68kea_pkg::OP_START, 3'($urandom), m68kea_pkg::MODE_IDX,
			2'($urandom), $urandom);
		queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, {16'($urandom), ext});
		if (!ext[8])
			return;
		iis = ext[2:0];
		if (iis == 3'd4)
			return;
		if (ext[5:4] >= 2'd2)
			queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, rand_value());
		if (iis == 0)
			return;
		if (iis[1])
			queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, rand_value());
		if ($urandom_range(0, 3) == 0)
			queue_word(m68kea_pkg::OP_WRITE_A, 3'($urandom), '0, '0, $urandom);
		queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, rand_value());
	endtask

	initial begin
		int n;
		logic [15:0] ext;
		for (int i = 0; i < 8; i++) begin
			m_dreg[i] = '0;
			m_areg[i] = '0;
		end
		m_pc = '0; m_phase = m68kea_pkg::PH_IDLE; m_ea_reg = '0;
		m_ext = '0; m_bd = '0; m_od = '0;

		queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, 32'h1234);
		queue_word(m68kea_pkg::OP_WRITE_D, 3'd7, '0, '0, 32'hFFFF_FFFF);
		queue_word(m68kea_pkg::OP_WRITE_A, 3'd7, '0, '0, 32'h0000_1000);
		queue_word(m68kea_pkg::OP_START, 3'd7, m68kea_pkg::MODE_POST, 2'd0, 32'hFFFF_FFFE);
		queue_word(m68kea_pkg::OP_START, 3'd7, m68kea_pkg::MODE_PRE, 2'd3, 32'd0);
		queue_word(m68kea_pkg::OP_START, 3'd3, m68kea_pkg::MODE_POST, 2'd2, 32'd4);
		queue_word(m68kea_pkg::OP_START, 3'd3, m68kea_pkg::MODE_PRE, 2'd1, 32'd4);
		queue_word(m68kea_pkg::OP_START, 3'd5, m68kea_pkg::MODE_DN, 2'd0, 32'd8);
		queue_word(m68kea_pkg::OP_START, 3'd5, m68kea_pkg::MODE_AN, 2'd0, 32'd8);
		queue_word(m68kea_pkg::OP_START, 3'd7, m68kea_pkg::MODE_IND, 2'd0, 32'd8);
		queue_word(m68kea_pkg::OP_START, 3'd2, 3'd7, 2'd0, 32'd10);
		queue_word(m68kea_pkg::OP_START, 3'd7, m68kea_pkg::MODE_D16, 2'd0, 32'd12);
		queue_word(m68kea_pkg::OP_WRITE_D, 3'd0, '0, '0, 32'h0000_8000);
		queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, 32'h0000_8000);
		queue_word(m68kea_pkg::OP_START, 3'd1, m68kea_pkg::MODE_D16, 2'd0, 32'd20);
		queue_word(m68kea_pkg::OP_START, 3'd1, m68kea_pkg::MODE_IDX, 2'd0, 32'd24);
		queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, 32'h0000_0680);
		queue_indexed(16'h7F34);
		queue_indexed(16'h01C5);
		queue_indexed(16'h0107);
		queue_indexed(16'hF903);
		queue_indexed(16'h0102);

		for (int i = 0; i < 790; i++) begin
			n = $urandom_range(0, 19);
			if (i == 400)
				hold_sender = 1;
			if (n < 3)
				queue_word(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom),
					2'($urandom), rand_value());
			else if (n < 5)
				queue_word(m68kea_pkg::OP_START, 3'($urandom), 3'($urandom),
					2'($urandom), rand_value());
			else if (n < 6)
				queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, rand_value());
			else if (n < 8) begin
				queue_word(m68kea_pkg::OP_START, 3'($urandom), m68kea_pkg::MODE_D16,
					2'($urandom), rand_value());
				queue_word(m68kea_pkg::OP_REPLY, '0, '0, '0, rand_value());
			end else begin
				ext = $urandom;
				if (ext[8] && ext[2:0] == 3'd4 && $urandom_range(0, 3) != 0)
					ext[2] = 1'b0;
				queue_indexed(ext);
			end
		end
		hold_sender = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() > 1500) @(posedge clk);
		while (pending_words.size() > 1000) @(posedge clk);
		// Starve the block until it has drained everything.
		hold_sender = 1;
		while (expected_results.size() != 0 || valid) @(posedge clk);
		hold_sender = 0;
		while (pending_words.size() > 200) @(posedge clk);
		quiet_tail = 1;
		while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
